// ===== src/dns_pkg.sv =====
// Shared widths, payload types and register codes of the depth shading block.
// No dependencies; every other file imports this package.
package dns_pkg;

  localparam int unsigned DepthW  = 16;
  localparam int unsigned ColorW  = 8;
  localparam int unsigned NumChan = 3;
  localparam int unsigned SqW     = 2 * DepthW;
  localparam int unsigned SumW    = SqW + 2;
  // Denominators at or above 2^DenW already force every channel to zero,
  // since 4*255*255 < 2^DenW - 1; clamp there.
  localparam int unsigned DenW    = 18;
  localparam int unsigned LimW    = 2 * ColorW + 2;
  localparam int unsigned QW      = DenW + ColorW;
  localparam int unsigned CandW   = QW + ColorW + 2;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [DenW-1:0]   DenSat    = {DenW{1'b1}};
  localparam logic [DepthW-1:0] NearReset = DepthW'(400);
  localparam logic [DepthW-1:0] FarReset  = DepthW'(8000);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_NEAR = 2'd0,
    CFG_FAR  = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [DepthW-1:0] depth_center;
    logic [DepthW-1:0] depth_right;
    logic [DepthW-1:0] depth_below;
    logic [NumChan-1:0][ColorW-1:0] color;  // 0 blue, 1 green, 2 red
  } pix_t;

  // Per-channel state of the bitwise root search: k so far, k*k*den, k*den, 4*c*c.
  typedef struct packed {
    logic [ColorW-1:0] k;
    logic [LimW-1:0]   p;
    logic [QW-1:0]     q;
    logic [LimW-1:0]   lim;
  } chan_t;

  typedef struct packed {
    logic [DenW-1:0]          den;
    chan_t [NumChan-1:0]      chan;
  } stage_t;

endpackage

// ===== src/dns_if.sv =====
// Valid/ready channel interfaces: pixel input, shaded output, register writes.
// Depends on dns_pkg.
interface dns_pix_if import dns_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DepthW-1:0] depth_center;
  logic [DepthW-1:0] depth_right;
  logic [DepthW-1:0] depth_below;
  logic [ColorW-1:0] blue_in;
  logic [ColorW-1:0] green_in;
  logic [ColorW-1:0] red_in;

  modport source (output valid, depth_center, depth_right, depth_below,
                  blue_in, green_in, red_in, input ready);
  modport sink   (input valid, depth_center, depth_right, depth_below,
                  blue_in, green_in, red_in, output ready);
endinterface

interface dns_rgb_if import dns_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ColorW-1:0] blue_out;
  logic [ColorW-1:0] green_out;
  logic [ColorW-1:0] red_out;

  modport source (output valid, blue_out, green_out, red_out, input ready);
  modport sink   (input valid, blue_out, green_out, red_out, output ready);
endinterface

interface dns_cfg_if import dns_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [DepthW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/depth_normal_shading_top.sv =====
// Top level of the depth gradient shading pipeline.
// Depends on dns_pkg, dns_if, dns_front and dns_root_step.
//
//   channel   modport      beat carries
//   pix_i     sink         three depths, blue/green/red in
//   rgb_o     source       blue/green/red out
//   cfg_i     sink         register index (0 near, 1 far), 16-bit data
//
// One pixel per clock while the output side takes beats; three front stages
// (range and gradient, squares, denominator) then one stage per result bit
// of the shift-and-add root search.
// Reset clears valid bits and loads near 400, far 8000; payload is not reset.
// A held output beat freezes every stage at once, so ready toggles with the
// output side and nothing is dropped or repeated. Register writes are always taken.
module depth_normal_shading_top import dns_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  dns_pix_if.sink   pix_i,
  dns_rgb_if.source rgb_o,
  dns_cfg_if.sink   cfg_i
);

  localparam int unsigned NumSteps = ColorW;

  logic [DepthW-1:0] near_q, far_q;
  logic              en;
  pix_t              pix;
  logic              vld [NumSteps+1];
  stage_t            stg [NumSteps+1];

  // Register writes: accept every beat, drop unknown indexes.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q <= NearReset;
      far_q  <= FarReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_NEAR: near_q <= cfg_i.data;
        CFG_FAR:  far_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Advance the whole pipeline unless the output beat is held.
  assign en          = !vld[NumSteps] || rgb_o.ready;
  assign pix_i.ready = en;

  always_comb begin
    pix.depth_center = pix_i.depth_center;
    pix.depth_right  = pix_i.depth_right;
    pix.depth_below  = pix_i.depth_below;
    pix.color[0]     = pix_i.blue_in;
    pix.color[1]     = pix_i.green_in;
    pix.color[2]     = pix_i.red_in;
  end

  dns_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pix_i.valid),
    .pix_i   (pix),
    .near_i  (near_q),
    .far_i   (far_q),
    .valid_o (vld[0]),
    .stage_o (stg[0])
  );

  // Search from the top result bit down, one bit per stage.
  for (genvar i = 0; i < NumSteps; i++) begin : g_step
    dns_root_step #(
      .BitIdx (NumSteps - 1 - i)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vld[i]),
      .stage_i (stg[i]),
      .valid_o (vld[i+1]),
      .stage_o (stg[i+1])
    );
  end

  // The last step register is the output register.
  assign rgb_o.valid     = vld[NumSteps];
  assign rgb_o.blue_out  = stg[NumSteps].chan[0].k;
  assign rgb_o.green_out = stg[NumSteps].chan[1].k;
  assign rgb_o.red_out   = stg[NumSteps].chan[2].k;

endmodule

// ===== src/dns_front.sv =====
// Front three stages: range check and gradient, squares and limits, denominator.
// Depends on dns_pkg.
module dns_front import dns_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  pix_t              pix_i,
  input  logic [DepthW-1:0] near_i,
  input  logic [DepthW-1:0] far_i,
  output logic              valid_o,
  output stage_t            stage_o
);

  logic                           v1_q, v2_q, v3_q;
  logic [DepthW-1:0]              dr_d, db_d, dr_q, db_q;
  logic [NumChan-1:0][ColorW-1:0] col_d, col_q;
  logic [SqW-1:0]                 sqr_q, sqb_q;
  logic [NumChan-1:0][LimW-1:0]   lim_d, lim_q;
  logic [SumW-1:0]                sum;
  stage_t                         stage_d, stage_q;
  logic                           in_range;

  // Stage 1: absolute gradients; out-of-range pixels get zero color so the root is zero.
  always_comb begin
    in_range = (pix_i.depth_center >= near_i) && (pix_i.depth_center <= far_i);
    dr_d = (pix_i.depth_right >= pix_i.depth_center) ?
           pix_i.depth_right - pix_i.depth_center : pix_i.depth_center - pix_i.depth_right;
    db_d = (pix_i.depth_below >= pix_i.depth_center) ?
           pix_i.depth_below - pix_i.depth_center : pix_i.depth_center - pix_i.depth_below;
    col_d = in_range ? pix_i.color : '0;
  end

  // Stage 2 input: limit 4*c*c per channel.
  always_comb begin
    for (int j = 0; j < NumChan; j++) begin
      lim_d[j] = LimW'({col_q[j], 2'b00}) * LimW'(col_q[j]);
    end
  end

  // Stage 3 input: den = 4 + dr^2 + db^2, clamped.
  always_comb begin
    sum = SumW'(sqr_q) + SumW'(sqb_q) + SumW'(4);
    stage_d.den = (sum > SumW'(DenSat)) ? DenSat : sum[DenW-1:0];
    for (int j = 0; j < NumChan; j++) begin
      stage_d.chan[j].k   = '0;
      stage_d.chan[j].p   = '0;
      stage_d.chan[j].q   = '0;
      stage_d.chan[j].lim = lim_q[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dr_q    <= dr_d;
      db_q    <= db_d;
      col_q   <= col_d;
      sqr_q   <= SqW'(dr_q) * SqW'(dr_q);
      sqb_q   <= SqW'(db_q) * SqW'(db_q);
      lim_q   <= lim_d;
      stage_q <= stage_d;
    end
  end

  assign valid_o = v3_q;
  assign stage_o = stage_q;

endmodule

// ===== src/dns_root_step.sv =====
// One bit of the integer root search k*k*den <= 4*c*c for all three channels.
// Depends on dns_pkg; shift-and-add only, no multiplier.
module dns_root_step import dns_pkg::*; #(
  parameter int unsigned BitIdx = 0
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   valid_i,
  input  stage_t stage_i,
  output logic   valid_o,
  output stage_t stage_o
);

  logic   valid_q;
  stage_t stage_d, stage_q;
  logic [NumChan-1:0][CandW-1:0] cand;

  // Trial t = k + 2^b: t*t*den = p + (q << (b+1)) + (den << 2b).
  always_comb begin
    stage_d = stage_i;
    for (int j = 0; j < NumChan; j++) begin
      cand[j] = CandW'(stage_i.chan[j].p)
              + (CandW'(stage_i.chan[j].q) << (BitIdx + 1))
              + (CandW'(stage_i.den) << (2 * BitIdx));
      if (cand[j] <= CandW'(stage_i.chan[j].lim)) begin
        stage_d.chan[j].k = stage_i.chan[j].k | ColorW'(1 << BitIdx);
        stage_d.chan[j].p = cand[j][LimW-1:0];
        stage_d.chan[j].q = stage_i.chan[j].q + (QW'(stage_i.den) << BitIdx);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule
